// ===== src/spx_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spx_pkg
// Shared widths, generator constants and controller/datapath interface types.
// ----------------------------------------------------------------------------
package spx_pkg;

   localparam int unsigned WordWidth = 64;
   localparam int unsigned HalfWidth = WordWidth / 2;

   localparam logic [WordWidth-1:0] GoldenInc = 64'h9e37_79b9_7f4a_7c15;
   localparam logic [WordWidth-1:0] MixMulA   = 64'hbf58_476d_1ce4_e5b9;
   localparam logic [WordWidth-1:0] MixMulB   = 64'h94d0_49bb_1331_11eb;
   localparam int unsigned MixShiftA = 30;
   localparam int unsigned MixShiftB = 27;
   localparam int unsigned MixShiftC = 31;

   typedef enum logic [3:0] {
      DP_NOP,
      DP_LOAD,       // latch request bound
      DP_THR_START,  // divider: (2^64 - n) mod n
      DP_THR_SAVE,
      DP_ADVANCE,    // counter += inc, first xor-shift
      DP_MUL_LO,
      DP_MUL_X1,
      DP_MUL_X2,
      DP_XS_B,
      DP_XS_C,
      DP_MOD_START,  // divider: z mod n
      DP_RESULT
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
      logic      mul_b;      // select second mix multiplier
      logic      load_seed;
   } dp_cmd_type;

   typedef struct packed {
      logic bound_zero;
      logic div_done;
      logic below_thr;
   } dp_status_type;

endpackage

// ===== src/spx_divider.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spx_divider
// Radix-2 restoring remainder unit, one dividend bit per cycle.
// ----------------------------------------------------------------------------
module spx_divider
   import spx_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [WordWidth-1:0] dividend,
   input  logic [WordWidth-1:0] divisor,
   output logic                 done,
   output logic [WordWidth-1:0] remainder
);

   localparam int unsigned CntWidth = $clog2(WordWidth + 1);

   logic [CntWidth-1:0]  cnt_ff, cnt_in;
   logic                 done_ff, done_in;
   logic [WordWidth-1:0] rem_ff, rem_in;
   logic [WordWidth-1:0] dvd_ff, dvd_in;
   logic [WordWidth-1:0] dsr_ff, dsr_in;
   logic [WordWidth:0]   trial;
   logic [WordWidth:0]   diff;
   logic                 busy;

   assign busy  = (cnt_ff != '0);
   assign trial = {rem_ff, dvd_ff[WordWidth-1]};
   assign diff  = trial - {1'b0, dsr_ff};

   always_comb begin
      cnt_in  = cnt_ff;
      done_in = done_ff;
      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      dsr_in  = dsr_ff;
      if (start) begin
         cnt_in  = CntWidth'(WordWidth);
         done_in = 1'b0;
         rem_in  = '0;
         dvd_in  = dividend;
         dsr_in  = divisor;
      end else if (busy) begin
         cnt_in = cnt_ff - 1'b1;
         dvd_in = {dvd_ff[WordWidth-2:0], 1'b0};
         // remainder stays below divisor, so the top bit drops out
         rem_in = diff[WordWidth] ? trial[WordWidth-1:0] : diff[WordWidth-1:0];
         if (cnt_ff == CntWidth'(1)) begin
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      dsr_ff <= dsr_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

`ifndef ASSERT_OFF
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy)
      else $error("divider restarted while busy");

   a_done_clears: assert property (@(posedge clock) disable iff (reset)
      start |=> (!done_ff && busy))
      else $error("divider done not cleared by start");

   a_rem_range: assert property (@(posedge clock) disable iff (reset)
      (done_ff && !busy) |-> (rem_ff < dsr_ff))
      else $error("remainder not below divisor");
`endif

endmodule

// ===== src/spx_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spx_datapath
// Generator counter, mix unit on a shared 32x32 multiplier, threshold and
// reduction through the remainder unit, result register.
// ----------------------------------------------------------------------------
module spx_datapath
   import spx_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  dp_cmd_type           cmd,
   output dp_status_type        status,
   input  logic [WordWidth-1:0] req_bound,
   input  logic [WordWidth-1:0] csr_seed,
   output logic [WordWidth-1:0] rsp_value,
   output logic                 rsp_range_error
);

   logic [WordWidth-1:0] counter_ff, counter_in;
   logic [WordWidth-1:0] bound_ff, bound_in;
   logic [WordWidth-1:0] thr_ff, thr_in;
   logic [WordWidth-1:0] z_ff, z_in;
   logic [WordWidth-1:0] acc_ff, acc_in;
   logic [WordWidth-1:0] value_ff, value_in;
   logic                 error_ff, error_in;

   logic [WordWidth-1:0] step;
   logic [WordWidth-1:0] mul_k;
   logic [HalfWidth-1:0] mul_a, mul_b;
   logic [WordWidth-1:0] product;

   logic                 div_start;
   logic [WordWidth-1:0] div_dividend;
   logic                 div_done;
   logic [WordWidth-1:0] div_rem;

   assign step  = counter_ff + GoldenInc;
   assign mul_k = cmd.mul_b ? MixMulB : MixMulA;

   // low 64 bits of z*k from three 32x32 partial products
   assign mul_a   = (cmd.op == DP_MUL_X2) ? z_ff[WordWidth-1:HalfWidth] : z_ff[HalfWidth-1:0];
   assign mul_b   = (cmd.op == DP_MUL_X1) ? mul_k[WordWidth-1:HalfWidth] : mul_k[HalfWidth-1:0];
   assign product = WordWidth'(mul_a) * WordWidth'(mul_b);

   assign div_start    = (cmd.op == DP_THR_START) || (cmd.op == DP_MOD_START);
   assign div_dividend = (cmd.op == DP_THR_START) ? ('0 - bound_ff) : z_ff;

   always_comb begin
      counter_in = counter_ff;
      bound_in   = bound_ff;
      thr_in     = thr_ff;
      z_in       = z_ff;
      acc_in     = acc_ff;
      value_in   = value_ff;
      error_in   = error_ff;
      if (cmd.load_seed) begin
         counter_in = csr_seed;
      end
      case (cmd.op)
         DP_LOAD:     bound_in = req_bound;
         DP_THR_SAVE: thr_in   = div_rem;
         DP_ADVANCE: begin
            counter_in = step;
            z_in       = step ^ (step >> MixShiftA);
         end
         DP_MUL_LO:   acc_in = product;
         DP_MUL_X1,
         DP_MUL_X2:   acc_in = acc_ff + {product[HalfWidth-1:0], {HalfWidth{1'b0}}};
         DP_XS_B:     z_in   = acc_ff ^ (acc_ff >> MixShiftB);
         DP_XS_C:     z_in   = acc_ff ^ (acc_ff >> MixShiftC);
         DP_RESULT: begin
            error_in = (bound_ff == '0);
            value_in = (bound_ff == '0) ? '0 : div_rem;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         counter_ff <= '0;
      end else begin
         counter_ff <= counter_in;
      end
      bound_ff <= bound_in;
      thr_ff   <= thr_in;
      z_ff     <= z_in;
      acc_ff   <= acc_in;
      value_ff <= value_in;
      error_ff <= error_in;
   end

   spx_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (bound_ff),
      .done      (div_done),
      .remainder (div_rem)
   );

   assign status.bound_zero = (bound_ff == '0);
   assign status.div_done   = div_done;
   assign status.below_thr  = (z_ff < thr_ff);

   assign rsp_value       = value_ff;
   assign rsp_range_error = error_ff;

endmodule

// ===== src/spx_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spx_ctrl
// Sequencer: threshold, draw/mix/reject loop, reduction, result handoff.
// ----------------------------------------------------------------------------
module spx_ctrl
   import spx_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   input  logic          csr_valid,
   output logic          csr_ready,
   output dp_cmd_type    cmd,
   input  dp_status_type status
);

   typedef enum logic [3:0] {
      IDLE,
      START,
      THR,
      ADV,
      MUL_A0,
      MUL_A1,
      MUL_A2,
      XS_B,
      MUL_B0,
      MUL_B1,
      MUL_B2,
      XS_C,
      CHECK,
      MOD,
      DONE
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   // result slot can take a beat this cycle
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in      = state_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      cmd.op        = DP_NOP;
      cmd.mul_b     = 1'b0;
      cmd.load_seed = 1'b0;
      case (state_ff)
         IDLE: begin
            cmd.load_seed = csr_valid;
            if (req_valid) begin
               cmd.op   = DP_LOAD;
               state_in = START;
            end
         end
         START: begin
            if (status.bound_zero) begin
               state_in = DONE;
            end else begin
               cmd.op   = DP_THR_START;
               state_in = THR;
            end
         end
         THR: begin
            if (status.div_done) begin
               cmd.op   = DP_THR_SAVE;
               state_in = ADV;
            end
         end
         ADV: begin
            cmd.op   = DP_ADVANCE;
            state_in = MUL_A0;
         end
         MUL_A0: begin
            cmd.op   = DP_MUL_LO;
            state_in = MUL_A1;
         end
         MUL_A1: begin
            cmd.op   = DP_MUL_X1;
            state_in = MUL_A2;
         end
         MUL_A2: begin
            cmd.op   = DP_MUL_X2;
            state_in = XS_B;
         end
         XS_B: begin
            cmd.op   = DP_XS_B;
            state_in = MUL_B0;
         end
         MUL_B0: begin
            cmd.op    = DP_MUL_LO;
            cmd.mul_b = 1'b1;
            state_in  = MUL_B1;
         end
         MUL_B1: begin
            cmd.op    = DP_MUL_X1;
            cmd.mul_b = 1'b1;
            state_in  = MUL_B2;
         end
         MUL_B2: begin
            cmd.op    = DP_MUL_X2;
            cmd.mul_b = 1'b1;
            state_in  = XS_C;
         end
         XS_C: begin
            cmd.op   = DP_XS_C;
            state_in = CHECK;
         end
         CHECK: begin
            // reject draws below the bias threshold
            if (status.below_thr) begin
               state_in = ADV;
            end else begin
               cmd.op   = DP_MOD_START;
               state_in = MOD;
            end
         end
         MOD: begin
            if (status.div_done) begin
               state_in = DONE;
            end
         end
         DONE: begin
            if (out_free) begin
               cmd.op       = DP_RESULT;
               rsp_valid_in = 1'b1;
               state_in     = IDLE;
            end
         end
         default: state_in = IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != IDLE);
   assign csr_ready = (state_ff == IDLE);
   assign rsp_valid = rsp_valid_ff;

`ifndef ASSERT_OFF
   a_result_posted: assert property (@(posedge clock) disable iff (reset)
      (state_ff == DONE && out_free) |=> (rsp_valid_ff && state_ff == IDLE))
      else $error("finished result not posted");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == DP_RESULT) |-> out_free)
      else $error("result register overwritten while held");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |=> rsp_valid_ff)
      else $error("result dropped while stalled");
`endif

endmodule

// ===== src/splitmix64_bounded_draw.sv =====
`timescale 1ns / 1ps
// Steps: load the bound, threshold in the remainder unit, a raw draw and mix
//   per try (redrawn while below the threshold), reduction, result.
// Requests: one at a time; the next is taken once the result is in the
//   output register.
// Zero bound: no remainder work, result flags a range error. Reset:
//   synchronous, counter cleared to 0.
// ----------------------------------------------------------------------------
// splitmix64_bounded_draw
// Unbiased bounded draw from a splitmix64 generator, seed set over csr port.
// ----------------------------------------------------------------------------
module splitmix64_bounded_draw
   import spx_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [WordWidth-1:0] req_bound,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [WordWidth-1:0] rsp_value,
   output logic                 rsp_range_error,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [WordWidth-1:0] csr_seed
);

   dp_cmd_type    cmd;
   dp_status_type status;

   spx_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .cmd       (cmd),
      .status    (status)
   );

   spx_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_bound       (req_bound),
      .csr_seed        (csr_seed),
      .rsp_value       (rsp_value),
      .rsp_range_error (rsp_range_error)
   );

endmodule

// ===== tb/splitmix64_bounded_draw_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// splitmix64_bounded_draw_test
// Self-checking bench for the bounded splitmix64 draw block. A local
// predictor tracks the generator counter and works out every draw, including
// rejection redraws. Tests cover directed edge bounds, seed reloads, full
// backpressure and long random runs with idle gaps on both sides.
// ----------------------------------------------------------------------------
module splitmix64_bounded_draw_test
   import spx_pkg::*;
();

   localparam int unsigned ResetCycles   = 11;
   localparam int unsigned QuietLimit    = 5000;
   localparam int unsigned RspHoldCycles = 500;
   localparam int unsigned TailCycles    = 300;
   localparam int unsigned IdlePct       = 30;

   typedef struct packed {
      logic [WordWidth-1:0] value;
      logic                 range_error;
   } draw_result_type;

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   logic [WordWidth-1:0] req_bound;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [WordWidth-1:0] rsp_value;
   logic                 rsp_range_error;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [WordWidth-1:0] csr_seed;

   logic [WordWidth-1:0] gen_counter = '0;
   draw_result_type      pending_draws[$];
   int unsigned          mismatch_count = 0;
   int unsigned          quiet_cycles = 0;
   bit                   idle_on = 1'b1;
   int unsigned          hold_requested = 0;
   int unsigned          hold_served = 0;
   int unsigned          hold_left = 0;

   splitmix64_bounded_draw DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_bound      (req_bound),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_value      (rsp_value),
      .rsp_range_error(rsp_range_error),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_seed       (csr_seed)
   );

   always #1 clock = ~clock;

   // advances gen_counter once per raw draw, redraws included
   function automatic draw_result_type predict_draw(input logic [WordWidth-1:0] bound);
      draw_result_type      r;
      logic [WordWidth-1:0] reject_below;
      logic [WordWidth-1:0] z;
      r.value       = '0;
      r.range_error = 1'b1;
      if (bound != '0) begin
         reject_below = (64'd0 - bound) % bound;
         do begin
            gen_counter = gen_counter + GoldenInc;
            z = gen_counter;
            z = (z ^ (z >> MixShiftA)) * MixMulA;
            z = (z ^ (z >> MixShiftB)) * MixMulB;
            z = z ^ (z >> MixShiftC);
         end while (z < reject_below);
         r.value       = z % bound;
         r.range_error = 1'b0;
      end
      return r;
   endfunction

   function automatic logic [WordWidth-1:0] pick_bound();
      logic [WordWidth-1:0] b;
      case ($urandom_range(9))
         0: b = '0;
         1: b = 64'($urandom_range(16, 1));
         2: b = {32'd0, $urandom};
         3, 4: b = {$urandom, $urandom};
         5: b = 64'd1 << $urandom_range(63);
         6: b = (64'd1 << 63) + 64'($urandom_range(255));   // heavy rejection
         7: b = ~64'd0 - 64'($urandom_range(255));
         8: b = (64'd1 << $urandom_range(63)) + 64'd1;
         default: b = {$urandom, $urandom} >> $urandom_range(63);
      endcase
      return b;
   endfunction

   task automatic report_mismatch(input string what, input logic [WordWidth-1:0] got,
                                  input logic [WordWidth-1:0] want);
      mismatch_count++;
      $display("%0t: %s: got %h, want %h", $realtime, what, got, want);
   endtask

   task automatic send_bound(input logic [WordWidth-1:0] bound);
      @(negedge clock);
      if (idle_on && $urandom_range(99) < IdlePct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(300, 1)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_bound <= bound;
      do @(posedge clock); while (!(req_valid && !req_stall));
      pending_draws.insert(pending_draws.size(), predict_draw(bound));
   endtask

   // sender goes quiet until every pending draw has come back
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_draws.size() != 0) @(posedge clock);
   endtask

   task automatic write_seed(input logic [WordWidth-1:0] seed_val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_seed  <= seed_val;
      do @(posedge clock); while (!csr_ready);
      gen_counter = seed_val;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic test_reset_state();
      send_bound(64'd1);
      send_bound(64'd0);
      send_bound(64'd2);
      send_bound(~64'd0);
      drain();
   endtask

   task automatic test_bound_edges();
      logic [WordWidth-1:0] edge_bounds[13] = '{
         64'd0, 64'd1, 64'd2, 64'd3, 64'h8000_0000_0000_0000,
         64'h8000_0000_0000_0001, ~64'd0, ~64'd1, 64'haaaa_aaaa_aaaa_aaaa,
         64'h5555_5555_5555_5555, 64'd0, 64'h1_0000_0000, 64'h1_0000_0001};
      write_seed(~64'd0);
      foreach (edge_bounds[i]) send_bound(edge_bounds[i]);
      drain();
   endtask

   task automatic test_seed_reload();
      logic [WordWidth-1:0] seeds[4];
      seeds = '{64'd0, ~64'd0, 64'h8000_0000_0000_0000, {$urandom, $urandom}};
      foreach (seeds[i]) begin
         write_seed(seeds[i]);
         send_bound(pick_bound());
         send_bound({$urandom, $urandom});
         drain();
      end
   endtask

   task automatic test_full_backpressure();
      idle_on = 1'b0;
      hold_requested++;
      repeat (8) send_bound(pick_bound());
      drain();
      idle_on = 1'b1;
   endtask

   task automatic test_random_draws();
      for (int phase = 0; phase < 8; phase++) begin
         case (phase)
            0: write_seed(64'd0);
            1: write_seed(~64'd0);
            2: write_seed(64'h8000_0000_0000_0000);
            default: write_seed({$urandom, $urandom});
         endcase
         idle_on = (phase != 3);   // one long stretch at full rate
         repeat (200) send_bound(pick_bound());
         drain();
      end
      idle_on = 1'b1;
   endtask

   always @(negedge clock) begin
      if (hold_served != hold_requested) begin
         hold_served = hold_requested;
         hold_left   = RspHoldCycles;
      end
      if (hold_left != 0) begin
         hold_left = hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= idle_on && ($urandom_range(99) < IdlePct);
      end
   end

   always @(posedge clock) begin : check_results
      draw_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_draws.size() == 0) begin
            report_mismatch("result with no draw pending", rsp_value, '0);
         end else begin
            want = pending_draws.pop_front();
            if (rsp_value !== want.value)
               report_mismatch("value", rsp_value, want.value);
            if (rsp_range_error !== want.range_error)
               report_mismatch("range_error", WordWidth'(rsp_range_error),
                               WordWidth'(want.range_error));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QuietLimit) begin
         $display("splitmix64_bounded_draw_test: errors");
         $finish;
      end
   end

   initial begin
      reset     = 1'b1;
      req_valid = 1'b0;
      req_bound = '0;
      csr_valid = 1'b0;
      csr_seed  = '0;
      repeat (ResetCycles) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_state();
      test_bound_edges();
      test_seed_reload();
      test_full_backpressure();
      test_random_draws();

      drain();
      repeat (TailCycles) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("splitmix64_bounded_draw_test: clean");
      end else begin
         $display("splitmix64_bounded_draw_test: errors");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
src/spx_pkg.sv
src/spx_divider.sv
src/spx_datapath.sv
src/spx_ctrl.sv
src/splitmix64_bounded_draw.sv
tb/splitmix64_bounded_draw_test.sv
